// ===== design/ptt_pkg.sv =====
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared constants, codes and types of the periodic timer table.
// ----------------------------------------------------------------------------
package ptt_pkg;

    // Table geometry and field widths.
    localparam int NUM_TIMERS = 16;
    localparam int TIME_WIDTH = 48;
    localparam int ID_W       = 16;
    localparam int INTERVAL_W = 24;
    localparam int PERIOD_W   = 34;
    localparam int SLOT_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
    localparam int ENTRY_W    = PERIOD_W + TIME_WIDTH;

    localparam logic [PERIOD_W-1:0] US_PER_MS = PERIOD_W'(1000);

    // Input item kinds.
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DUPLICATE = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // Update request from the controller to the id directory.
    typedef struct packed {
        logic              add_en;
        logic              rem_en;
        logic [SLOT_W-1:0] slot;
    } dir_op_t;

    // Lookup results of the id directory.
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] hit_slot;
        logic              full;
        logic [SLOT_W-1:0] free_slot;
        logic [CNT_W-1:0]  count;
    } dir_stat_t;

    // Slot that holds a given position in ascending id order.
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   id;
    } dir_rank_t;

endpackage

// ===== design/periodic_timer_table.sv =====
// ----------------------------------------------------------------------------
// periodic_timer_table
// Table of periodic timers keyed by id, with add, remove and tick transactions.
// ----------------------------------------------------------------------------
// An add or remove transaction is accepted, then executed, and returns one
// status result; an output stall holds the execute step. A tick visits the
// timers in ascending id order, one per cycle while no output stall holds an
// expiry, which is the rate of the single read port of the period/start RAM,
// and then hands out the final expiry.
// The RAM needs no clearing after reset, since only slots marked valid
// are ever read. The timer mode register is written through its own port,
// which is always ready, and must be written only while the block is idle.
module periodic_timer_table (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     kind,
    input  logic [ptt_pkg::ID_W-1:0]       timer_id,
    input  logic [ptt_pkg::INTERVAL_W-1:0] interval_ms,
    input  logic [ptt_pkg::TIME_WIDTH-1:0] now_us,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           fired,
    output logic [ptt_pkg::ID_W-1:0]       event_id,
    output logic [1:0]                     status,
    output logic                           last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           timer_mode
);

    localparam int SW = ptt_pkg::SLOT_W;
    localparam int CW = ptt_pkg::CNT_W;
    localparam int TW = ptt_pkg::TIME_WIDTH;
    localparam int PW = ptt_pkg::PERIOD_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_EVAL,
        S_FLUSH
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]                     kind_reg, kind_next;
    logic [ptt_pkg::ID_W-1:0]       id_reg, id_next;
    logic [ptt_pkg::INTERVAL_W-1:0] interval_reg, interval_next;
    logic [TW-1:0]                  now_reg, now_next;
    logic [SW-1:0]                  cur_reg, cur_next;
    logic [SW-1:0]                  eval_slot_reg, eval_slot_next;
    logic [ptt_pkg::ID_W-1:0]       eval_id_reg, eval_id_next;
    logic                           pend_valid_reg, pend_valid_next;
    logic [ptt_pkg::ID_W-1:0]       pend_id_reg, pend_id_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           fired_reg, fired_next;
    logic [ptt_pkg::ID_W-1:0]       event_id_reg, event_id_next;
    logic [1:0]                     status_reg, status_next;
    logic                           last_reg, last_next;
    logic                           mode_reg;

    ptt_pkg::dir_op_t   dir_op;
    ptt_pkg::dir_stat_t dir_stat;
    ptt_pkg::dir_rank_t dir_rank;
    logic [SW-1:0]      query_rank;

    logic                     ram_we;
    logic [SW-1:0]            ram_waddr;
    logic [ptt_pkg::ENTRY_W-1:0] ram_wdata;
    logic                     ram_re;
    logic [ptt_pkg::ENTRY_W-1:0] ram_rdata;

    logic          in_accept;
    logic          out_free;
    logic [CW-1:0] cur_succ;
    logic          tick_done;
    logic [PW-1:0] period_calc;

    logic [PW-1:0] ent_period;
    logic [TW-1:0] ent_start;
    logic [TW-1:0] elapsed;
    logic [TW-1:0] period_ext;
    logic [TW-1:0] twice_ext;
    logic          ent_negative;
    logic          ent_fires;
    logic [TW-1:0] start_upd;
    logic          can_go;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    // Timer mode register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg <= timer_mode;
        end
    end

    // Rank sequencing over the sorted table during a tick.
    assign cur_succ   = CW'(cur_reg) + 1'b1;
    assign tick_done  = (cur_succ == dir_stat.count);
    assign query_rank = (state_reg == S_EXEC) ? '0 : cur_succ[SW-1:0];

    // Period in microseconds for an add; fits in the period width.
    assign period_calc = PW'(interval_reg) * ptt_pkg::US_PER_MS;

    // Evaluation of the slot whose entry has just been read.
    always_comb
    begin
        ent_period   = ram_rdata[TW +: PW];
        ent_start    = ram_rdata[TW-1:0];
        elapsed      = now_reg - ent_start;
        period_ext   = TW'(ent_period);
        twice_ext    = TW'({ent_period, 1'b0});
        ent_negative = elapsed[TW-1];
        ent_fires    = !ent_negative && (elapsed > period_ext);
        if (ent_negative || (elapsed > twice_ext) || mode_reg)
        begin
            start_upd = now_reg;
        end
        else
        begin
            start_upd = ent_start + period_ext;
        end
    end

    assign can_go = !(ent_fires && pend_valid_reg) || out_free;

    // Controller next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        id_next         = id_reg;
        interval_next   = interval_reg;
        now_next        = now_reg;
        cur_next        = cur_reg;
        eval_slot_next  = eval_slot_reg;
        eval_id_next    = eval_id_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        out_valid_next  = out_valid_reg && out_stall;
        fired_next      = fired_reg;
        event_id_next   = event_id_reg;
        status_next     = status_reg;
        last_next       = last_reg;
        dir_op          = '0;
        ram_we          = 1'b0;
        ram_waddr       = eval_slot_reg;
        ram_wdata       = {ent_period, start_upd};
        ram_re          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    kind_next     = kind;
                    id_next       = timer_id;
                    interval_next = interval_ms;
                    now_next      = now_us;
                    state_next    = S_EXEC;
                end
            end

            S_EXEC:
            begin
                case (kind_reg)
                    ptt_pkg::KIND_ADD:
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            fired_next     = 1'b0;
                            event_id_next  = id_reg;
                            last_next      = 1'b1;
                            if (dir_stat.hit)
                            begin
                                status_next = ptt_pkg::ST_DUPLICATE;
                            end
                            else if (dir_stat.full)
                            begin
                                status_next = ptt_pkg::ST_FULL;
                            end
                            else
                            begin
                                status_next   = ptt_pkg::ST_OK;
                                dir_op.add_en = 1'b1;
                                dir_op.slot   = dir_stat.free_slot;
                                ram_we        = 1'b1;
                                ram_waddr     = dir_stat.free_slot;
                                ram_wdata     = {period_calc, now_reg};
                            end
                            state_next = S_IDLE;
                        end
                    end

                    ptt_pkg::KIND_REMOVE:
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            fired_next     = 1'b0;
                            event_id_next  = id_reg;
                            last_next      = 1'b1;
                            if (dir_stat.hit)
                            begin
                                status_next   = ptt_pkg::ST_OK;
                                dir_op.rem_en = 1'b1;
                                dir_op.slot   = dir_stat.hit_slot;
                            end
                            else
                            begin
                                status_next = ptt_pkg::ST_NOT_FOUND;
                            end
                            state_next = S_IDLE;
                        end
                    end

                    ptt_pkg::KIND_TICK:
                    begin
                        if (dir_stat.count == '0)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            ram_re          = 1'b1;
                            eval_slot_next  = dir_rank.slot;
                            eval_id_next    = dir_rank.id;
                            cur_next        = '0;
                            pend_valid_next = 1'b0;
                            state_next      = S_EVAL;
                        end
                    end

                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_EVAL:
            begin
                if (can_go)
                begin
                    ram_we = ent_negative || ent_fires;
                    // An expiry waits in the pending register until the next
                    // one, or the end of the scan, shows whether it is the last.
                    if (ent_fires)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            fired_next     = 1'b1;
                            event_id_next  = pend_id_reg;
                            status_next    = ptt_pkg::ST_OK;
                            last_next      = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = eval_id_reg;
                    end
                    if (tick_done)
                    begin
                        state_next = (pend_valid_reg || ent_fires) ? S_FLUSH : S_IDLE;
                    end
                    else
                    begin
                        ram_re         = 1'b1;
                        eval_slot_next = dir_rank.slot;
                        eval_id_next   = dir_rank.id;
                        cur_next       = cur_succ[SW-1:0];
                    end
                end
            end

            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    fired_next      = 1'b1;
                    event_id_next   = pend_id_reg;
                    status_next     = ptt_pkg::ST_OK;
                    last_next       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Controller state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            kind_reg       <= '0;
            id_reg         <= '0;
            interval_reg   <= '0;
            now_reg        <= '0;
            cur_reg        <= '0;
            eval_slot_reg  <= '0;
            eval_id_reg    <= '0;
            pend_id_reg    <= '0;
            fired_reg      <= 1'b0;
            event_id_reg   <= '0;
            status_reg     <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            kind_reg       <= kind_next;
            id_reg         <= id_next;
            interval_reg   <= interval_next;
            now_reg        <= now_next;
            cur_reg        <= cur_next;
            eval_slot_reg  <= eval_slot_next;
            eval_id_reg    <= eval_id_next;
            pend_id_reg    <= pend_id_next;
            fired_reg      <= fired_next;
            event_id_reg   <= event_id_next;
            status_reg     <= status_next;
            last_reg       <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign fired     = fired_reg;
    assign event_id  = event_id_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    // Id directory.
    ptt_dir u_dir (
        .clk        (clk),
        .rst_n      (rst_n),
        .lookup_id  (id_reg),
        .op         (dir_op),
        .query_rank (query_rank),
        .stat       (dir_stat),
        .rank_hit   (dir_rank)
    );

    // Period and start time of every slot.
    ptt_ram #(
        .DEPTH (ptt_pkg::NUM_TIMERS),
        .WIDTH (ptt_pkg::ENTRY_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (dir_rank.slot),
        .rd_data (ram_rdata)
    );

`ifndef SYNTHESIS
    // The occupancy count never exceeds the table size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dir_stat.count <= CW'(ptt_pkg::NUM_TIMERS))
        else $error("timer count exceeds table size");

    // A pending expiry exists only while a tick is being scanned or flushed.
    a_pend_state: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == S_EVAL || state_reg == S_FLUSH))
        else $error("pending expiry outside a tick");

    // Expiry results always carry the ok status.
    a_fired_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && fired_reg) |-> (status_reg == ptt_pkg::ST_OK))
        else $error("expiry result with non-ok status");

    // The directory is never changed during a tick scan.
    a_dir_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL || state_reg == S_FLUSH) |-> !(dir_op.add_en || dir_op.rem_en))
        else $error("directory update during a tick");
`endif

endmodule

// ===== design/ptt_ram.sv =====
// ----------------------------------------------------------------------------
// ptt_ram
// Simple dual-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ptt_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/ptt_dir.sv =====
// ----------------------------------------------------------------------------
// ptt_dir
// Id directory: valid bits, ids and the ascending-id rank of every slot.
// ----------------------------------------------------------------------------
module ptt_dir (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [ptt_pkg::ID_W-1:0]   lookup_id,
    input  ptt_pkg::dir_op_t          op,
    input  logic [ptt_pkg::SLOT_W-1:0] query_rank,
    output ptt_pkg::dir_stat_t        stat,
    output ptt_pkg::dir_rank_t        rank_hit
);

    localparam int N = ptt_pkg::NUM_TIMERS;
    localparam int SW = ptt_pkg::SLOT_W;

    logic [N-1:0]               valid_reg;
    logic [ptt_pkg::ID_W-1:0]   id_reg [N];
    logic [SW-1:0]              rank_reg [N];
    logic [ptt_pkg::CNT_W-1:0]  count_reg;
    logic [ptt_pkg::CNT_W-1:0]  count_next;

    logic [N-1:0] match;
    logic [N-1:0] less;
    logic [N-1:0] greater;
    logic [N-1:0] sel;
    logic [SW-1:0] new_rank;

    // Per-slot comparisons against the looked-up id and the queried rank.
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            match[i]   = valid_reg[i] && (id_reg[i] == lookup_id);
            less[i]    = valid_reg[i] && (id_reg[i] < lookup_id);
            greater[i] = valid_reg[i] && (id_reg[i] > lookup_id);
            sel[i]     = valid_reg[i] && (rank_reg[i] == query_rank);
        end
        new_rank = SW'($countones(less));
    end

    // Encoders: hit and rank selections are one-hot, the free slot is the lowest.
    always_comb
    begin
        stat.hit       = |match;
        stat.hit_slot  = '0;
        stat.full      = &valid_reg;
        stat.free_slot = '0;
        stat.count     = count_reg;
        rank_hit.slot  = '0;
        rank_hit.id    = '0;
        for (int i = 0; i < N; i++)
        begin
            if (match[i])
            begin
                stat.hit_slot = stat.hit_slot | SW'(i);
            end
            if (sel[i])
            begin
                rank_hit.slot = rank_hit.slot | SW'(i);
                rank_hit.id   = rank_hit.id | id_reg[i];
            end
        end
        for (int i = N - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                stat.free_slot = SW'(i);
            end
        end
    end

    // Occupancy count.
    always_comb
    begin
        count_next = count_reg;
        if (op.add_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (op.rem_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Valid bits and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (op.add_en)
            begin
                valid_reg[op.slot] <= 1'b1;
            end
            else if (op.rem_en)
            begin
                valid_reg[op.slot] <= 1'b0;
            end
        end
    end

    // Ids and ranks: entries above the new or removed id shift by one.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
        begin
            if (op.add_en && (op.slot == SW'(i)))
            begin
                id_reg[i]   <= lookup_id;
                rank_reg[i] <= new_rank;
            end
            else if (op.add_en && greater[i])
            begin
                rank_reg[i] <= rank_reg[i] + 1'b1;
            end
            else if (op.rem_en && greater[i])
            begin
                rank_reg[i] <= rank_reg[i] - 1'b1;
            end
        end
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the periodic timer table. A queue of add, remove
// and tick transactions feeds a driver with random gaps. A shadow copy of the
// timer table predicts each status and expiry result. A monitor that stalls
// at random compares every result, field by field, in order. The timer mode
// is switched between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [1:0]                     KIND_UNUSED  = 2'd3;
    localparam logic [ptt_pkg::TIME_WIDTH-1:0] TIME_MAX     = '1;
    localparam int                             DRAIN_CYCLES = 40;
    localparam logic                           MODE_ABS     = 1'b0;
    localparam logic                           MODE_REL     = 1'b1;

    typedef struct {
        logic [1:0]                     kind;
        logic [ptt_pkg::ID_W-1:0]       id;
        logic [ptt_pkg::INTERVAL_W-1:0] interval;
        logic [ptt_pkg::TIME_WIDTH-1:0] now;
    } request_t;

    typedef struct {
        logic                     fired;
        logic [ptt_pkg::ID_W-1:0] id;
        logic [1:0]               status;
        logic                     last;
    } timer_event_t;

    // Block ports.
    logic                           clk         = 1'b0;
    logic                           rst_n       = 1'b0;
    logic                           in_valid    = 1'b0;
    logic                           in_stall;
    logic [1:0]                     kind        = ptt_pkg::KIND_TICK;
    logic [ptt_pkg::ID_W-1:0]       timer_id    = '0;
    logic [ptt_pkg::INTERVAL_W-1:0] interval_ms = '0;
    logic [ptt_pkg::TIME_WIDTH-1:0] now_us      = '0;
    logic                           out_valid;
    logic                           out_stall   = 1'b0;
    logic                           fired;
    logic [ptt_pkg::ID_W-1:0]       event_id;
    logic [1:0]                     status;
    logic                           last;
    logic                           cfg_valid   = 1'b0;
    logic                           cfg_ready;
    logic                           timer_mode  = MODE_ABS;

    // Shadow copy of the timer table.
    logic                           restart_mode;
    logic                           shadow_valid  [ptt_pkg::NUM_TIMERS];
    logic [ptt_pkg::ID_W-1:0]       shadow_id     [ptt_pkg::NUM_TIMERS];
    logic [ptt_pkg::PERIOD_W-1:0]   shadow_period [ptt_pkg::NUM_TIMERS];
    logic [ptt_pkg::TIME_WIDTH-1:0] shadow_start  [ptt_pkg::NUM_TIMERS];

    request_t     queued_requests[$];
    timer_event_t awaited_events[$];
    request_t     in_flight;
    timer_event_t want;
    int           send_gap    = 0;
    int           stall_left  = 0;
    int           calm_timer  = 0;
    logic         driver_calm = 1'b0;
    logic         sink_calm   = 1'b0;
    int           failures    = 0;

    periodic_timer_table dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .timer_id    (timer_id),
        .interval_ms (interval_ms),
        .now_us      (now_us),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .fired       (fired),
        .event_id    (event_id),
        .status      (status),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .timer_mode  (timer_mode)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Slot holding a valid timer with this id, or -1.
    function automatic int find_timer(logic [ptt_pkg::ID_W-1:0] id);
        for (int i = 0; i < ptt_pkg::NUM_TIMERS; i++)
        begin
            if (shadow_valid[i] && shadow_id[i] == id)
                return i;
        end
        return -1;
    endfunction

    // Apply one accepted transaction to the shadow table and queue its results.
    function automatic void apply_request(request_t r);
        int                             first;
        int                             hit;
        int                             slot;
        int                             best;
        int                             prev;
        logic [ptt_pkg::TIME_WIDTH-1:0] elapsed;
        logic [63:0]                    twice_period;
        timer_event_t                   ev;
        first = awaited_events.size();
        ev = '{1'b0, r.id, ptt_pkg::ST_OK, 1'b0};
        case (r.kind)
            ptt_pkg::KIND_ADD:
            begin
                hit = find_timer(r.id);
                if (hit >= 0)
                    ev.status = ptt_pkg::ST_DUPLICATE;
                else
                begin
                    // The lowest free slot takes the new timer.
                    slot = -1;
                    for (int i = ptt_pkg::NUM_TIMERS - 1; i >= 0; i--)
                    begin
                        if (!shadow_valid[i])
                            slot = i;
                    end
                    if (slot < 0)
                        ev.status = ptt_pkg::ST_FULL;
                    else
                    begin
                        shadow_valid[slot]  = 1'b1;
                        shadow_id[slot]     = r.id;
                        shadow_period[slot] = r.interval * ptt_pkg::US_PER_MS;
                        shadow_start[slot]  = r.now;
                    end
                end
                awaited_events.push_back(ev);
            end
            ptt_pkg::KIND_REMOVE:
            begin
                hit = find_timer(r.id);
                if (hit >= 0)
                    shadow_valid[hit] = 1'b0;
                else
                    ev.status = ptt_pkg::ST_NOT_FOUND;
                awaited_events.push_back(ev);
            end
            ptt_pkg::KIND_TICK:
            begin
                // Visit the valid timers in ascending id order.
                prev = -1;
                do
                begin
                    best = -1;
                    for (int i = 0; i < ptt_pkg::NUM_TIMERS; i++)
                    begin
                        if (shadow_valid[i] && int'(shadow_id[i]) > prev &&
                            (best < 0 || shadow_id[i] < shadow_id[best]))
                            best = i;
                    end
                    if (best >= 0)
                    begin
                        prev = int'(shadow_id[best]);
                        elapsed = r.now - shadow_start[best];
                        twice_period = 64'(shadow_period[best]) << 1;
                        if (elapsed[ptt_pkg::TIME_WIDTH-1])
                            shadow_start[best] = r.now;
                        else if (elapsed > shadow_period[best])
                        begin
                            if (64'(elapsed) > twice_period || restart_mode == MODE_REL)
                                shadow_start[best] = r.now;
                            else
                                shadow_start[best] = shadow_start[best] + shadow_period[best];
                            ev = '{1'b1, shadow_id[best], ptt_pkg::ST_OK, 1'b0};
                            awaited_events.push_back(ev);
                        end
                    end
                end while (best >= 0);
            end
            default:
            begin
            end
        endcase
        if (awaited_events.size() > first)
            awaited_events[awaited_events.size() - 1].last = 1'b1;
    endfunction

    // Gap length: mostly none or short, now and then long.
    function automatic int idle_length(logic calm);
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void push_request(logic [1:0] k, logic [ptt_pkg::ID_W-1:0] id,
                                         logic [ptt_pkg::INTERVAL_W-1:0] interval,
                                         logic [ptt_pkg::TIME_WIDTH-1:0] now);
        request_t r;
        r = '{k, id, interval, now};
        queued_requests.push_back(r);
    endfunction

    // Periods of quiet on both sides, re-rolled every so often.
    always @(posedge clk)
    begin
        if (calm_timer == 0)
        begin
            calm_timer = $urandom_range(50, 150);
            driver_calm <= ($urandom_range(0, 3) == 0);
            sink_calm   <= ($urandom_range(0, 3) == 0);
        end
        else
            calm_timer--;
    end

    // Driver: predicts each accepted transaction, then presents the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                apply_request(in_flight);
            if (!(in_valid && in_stall))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (queued_requests.size() > 0)
                begin
                    in_flight = queued_requests.pop_front();
                    kind        <= in_flight.kind;
                    timer_id    <= in_flight.id;
                    interval_ms <= in_flight.interval;
                    now_us      <= in_flight.now;
                    in_valid    <= 1'b1;
                    send_gap = idle_length(driver_calm);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted result against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_events.size() == 0)
                begin
                    $error("unexpected result: fired %0d event_id %0d status %0d",
                           fired, event_id, status);
                    failures++;
                end
                else
                begin
                    want = awaited_events.pop_front();
                    if (fired !== want.fired)
                    begin
                        $error("fired: expected %0d, got %0d", want.fired, fired);
                        failures++;
                    end
                    if (event_id !== want.id)
                    begin
                        $error("event_id: expected %0d, got %0d", want.id, event_id);
                        failures++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        failures++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, last);
                        failures++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left = idle_length(sink_calm);
                out_stall <= (stall_left > 0);
            end
        end
    end

    // Write the timer mode register; the block must be idle.
    task automatic write_mode(input logic mode);
        cfg_valid  <= 1'b1;
        timer_mode <= mode;
        do
            @(posedge clk);
        while (!cfg_ready);
        restart_mode = mode;
        cfg_valid <= 1'b0;
    endtask

    // Wait until every transaction is sent and every result is in, then let
    // a tick that fires nothing run out. The check runs at the falling edge,
    // once the driver and the monitor have settled.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (queued_requests.size() != 0 || in_valid || awaited_events.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic queue_directed();
        push_request(ptt_pkg::KIND_TICK, '0, '0, '0);             // empty table, quiet
        push_request(KIND_UNUSED, '1, '1, TIME_MAX);              // unused kind, ignored
        push_request(ptt_pkg::KIND_REMOVE, 16'h1234, '0, '0);     // unknown id
        push_request(ptt_pkg::KIND_ADD, '0, '0, '0);              // zero period
        push_request(ptt_pkg::KIND_ADD, '1, '1, TIME_MAX);        // widest fields
        push_request(ptt_pkg::KIND_ADD, '0, 24'd5, 48'd100);      // duplicate id
        push_request(ptt_pkg::KIND_TICK, '0, '0, 48'd5);          // zero period fires
        push_request(ptt_pkg::KIND_TICK, '0, '0, 48'd4);          // time went backwards
        for (int i = 1; i <= 14; i++)
            push_request(ptt_pkg::KIND_ADD, ptt_pkg::ID_W'(i), ptt_pkg::INTERVAL_W'(i),
                         48'd10000);
        push_request(ptt_pkg::KIND_ADD, 16'd100, 24'd1, '0);      // table full
        push_request(ptt_pkg::KIND_REMOVE, '0, '0, '0);
        push_request(ptt_pkg::KIND_ADD, 16'd200, 24'd1, 48'd20000); // reuses lowest slot
        // Short periods resync, the longer ones advance by one period.
        push_request(ptt_pkg::KIND_TICK, '0, '0, 48'd30000);
        push_request(ptt_pkg::KIND_TICK, '0, '0, 48'd31500);
    endtask

    // Mostly a small id pool and short periods on a clock that moves forward,
    // so timers fill the table and fire often; the rest is noise.
    task automatic queue_random_phase(input int count,
                                      input logic [ptt_pkg::TIME_WIDTH-1:0] start_us);
        logic [ptt_pkg::TIME_WIDTH-1:0] clock_us;
        request_t                       r;
        int                             roll;
        clock_us = start_us;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            clock_us = clock_us + ptt_pkg::TIME_WIDTH'($urandom_range(0, 2500));
            r.id       = ptt_pkg::ID_W'($urandom_range(0, 23));
            r.interval = ptt_pkg::INTERVAL_W'($urandom_range(0, 6));
            r.now      = clock_us;
            if (roll < 45)
                r.kind = ptt_pkg::KIND_TICK;
            else if (roll < 70)
                r.kind = ptt_pkg::KIND_ADD;
            else if (roll < 85)
                r.kind = ptt_pkg::KIND_REMOVE;
            else if (roll < 88)
            begin
                r.kind = ptt_pkg::KIND_TICK;
                r.now  = clock_us - ptt_pkg::TIME_WIDTH'($urandom_range(1, 5000));
            end
            else
            begin
                r.kind     = (roll < 91) ? KIND_UNUSED : 2'($urandom_range(0, 2));
                r.id       = ptt_pkg::ID_W'($urandom);
                r.interval = ptt_pkg::INTERVAL_W'($urandom);
                r.now      = ptt_pkg::TIME_WIDTH'({$urandom, $urandom});
            end
            queued_requests.push_back(r);
        end
    endtask

    // Main sequence.
    initial
    begin
        restart_mode = MODE_ABS;
        foreach (shadow_valid[i])
            shadow_valid[i] = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        write_mode(MODE_ABS);
        queue_directed();
        wait_idle();

        write_mode(MODE_REL);
        queue_random_phase(100, ptt_pkg::TIME_WIDTH'({$urandom, $urandom}) >> 2);
        wait_idle();

        // Start the clock just below the wrap point.
        write_mode(MODE_ABS);
        queue_random_phase(100, TIME_MAX - ptt_pkg::TIME_WIDTH'(200000));
        wait_idle();

        write_mode(MODE_REL);
        queue_random_phase(100, '0);
        wait_idle();

        if (failures == 0 && awaited_events.size() == 0)
            $display("periodic_timer_table verification clean");
        else
            $display("periodic_timer_table verification failed");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #10_000_000;
        $display("periodic_timer_table verification failed");
        $finish;
    end

endmodule
